// ----- rtl/pppoe_discovery_tag_parser_macros.svh -----
// assertion macros for the pppoe discovery tag parser checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef PPPOE_DISCOVERY_TAG_PARSER_MACROS_SVH
`define PPPOE_DISCOVERY_TAG_PARSER_MACROS_SVH

// same-cycle implication
`define PDTP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PDTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pdtp_pkg.sv -----
// types and constants for the pppoe discovery tag parser
// no dependencies
package pdtp_pkg;

  localparam int unsigned HDR_LEN        = 6;
  localparam int unsigned TAG_HDR_LEN    = 4;
  localparam int unsigned POS_W          = 17;
  localparam int unsigned RES_DEPTH_DFLT = 4;

  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_TAG       = 3'd1,
    KIND_VALUE     = 3'd2,
    KIND_DONE      = 3'd3,
    KIND_SHORT     = 3'd4,
    KIND_TAGHDR_OV = 3'd5,
    KIND_VALUE_OV  = 3'd6
  } result_kind_e;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_TAGHDR = 4'b0010,
    PH_VALUE  = 4'b0100,
    PH_IDLE   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] captured_length;
    logic        last_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [3:0]  version;
    logic [3:0]  frame_type;
    logic [7:0]  code;
    logic [15:0] session_id;
    logic [15:0] payload_length;
    logic [15:0] tag_type;
    logic [15:0] tag_length;
    logic [7:0]  value_byte;
    logic        last_of_run;
  } out_word_t;

  // up to two results written into the queue per accepted byte
  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  w0;
    out_word_t  w1;
  } push_t;

endpackage

// ----- rtl/pppoe_discovery_tag_parser.sv -----
// pppoe discovery tag parser: one packet byte per word in, header, tag and
// value records out; the results of an accepted byte are written into the
// result queue; one byte accepted per cycle while the queue has room for two
// words, results leave at one per cycle while out_ready_i is high; a byte
// with two results takes two queue words; async active-low reset returns to
// the header phase with an empty queue
module pppoe_discovery_tag_parser import pdtp_pkg::*; #(
  parameter int unsigned ResDepth = RES_DEPTH_DFLT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  push_t push;
  logic  accept;

  assign accept = in_valid_i && in_ready_o;

  pdtp_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .word_i   (in_word_i),
    .push_o   (push)
  );

  pdtp_res_queue #(
    .Depth (ResDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ----- rtl/pdtp_parse.sv -----
// per-byte parse step: phase, position, header, tag and remaining-count state registers
// depends on pdtp_pkg
module pdtp_parse import pdtp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_word_t word_i,
  output push_t    push_o
);

  phase_e            phase_q, phase_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [47:0]       hdr_q, hdr_d;
  logic [31:0]       tag_q, tag_d;
  logic [15:0]       rem_q, rem_d;

  out_word_t         res0, res1;
  logic [1:0]        n;
  logic [47:0]       hdr_sh;
  logic [31:0]       tag_sh;
  logic [POS_W-1:0]  end_w;
  logic [POS_W:0]    pos_p1;
  logic [POS_W-1:0]  left;
  logic [15:0]       rem_dec;
  logic [7:0]        b;

  function automatic out_word_t mk(result_kind_e kind);
    out_word_t w;
    w             = '0;
    w.result_kind = kind;
    return w;
  endfunction

  always_comb begin
    b       = word_i.data_byte;
    phase_d = phase_q;
    pos_d   = (pos_q == {POS_W{1'b1}}) ? pos_q : pos_q + 1'b1;
    hdr_d   = hdr_q;
    tag_d   = tag_q;
    rem_d   = rem_q;
    res0    = '0;
    res1    = '0;
    n       = 2'd0;
    hdr_sh  = {hdr_q[39:0], b};
    tag_sh  = {tag_q[23:0], b};
    end_w   = POS_W'(HDR_LEN) + {1'b0, hdr_q[15:0]};
    pos_p1  = {1'b0, pos_q} + 1'b1;
    left    = (pos_p1 < {1'b0, end_w}) ? POS_W'({1'b0, end_w} - pos_p1) : '0;
    rem_dec = (rem_q == '0) ? '0 : rem_q - 1'b1;

    case (phase_q)
      PH_HEADER: begin
        hdr_d = hdr_sh;
        if (pos_q == '0 && word_i.captured_length < 16'(HDR_LEN)) begin
          res0    = mk(KIND_SHORT);
          n       = 2'd1;
          phase_d = PH_IDLE;
        end else if (pos_q == POS_W'(HDR_LEN - 1)) begin
          if ({1'b0, hdr_sh[15:0]} + 17'(HDR_LEN) > {1'b0, word_i.captured_length}) begin
            res0    = mk(KIND_SHORT);
            n       = 2'd1;
            phase_d = PH_IDLE;
          end else begin
            res0                = mk(KIND_HEADER);
            res0.version        = hdr_sh[47:44];
            res0.frame_type     = hdr_sh[43:40];
            res0.code           = hdr_sh[39:32];
            res0.session_id     = hdr_sh[31:16];
            res0.payload_length = hdr_sh[15:0];
            n                   = 2'd1;
            if (hdr_sh[15:0] == '0) begin
              res1    = mk(KIND_DONE);
              n       = 2'd2;
              phase_d = PH_IDLE;
            end else begin
              phase_d = PH_TAGHDR;
              rem_d   = 16'(TAG_HDR_LEN);
              tag_d   = '0;
            end
          end
        end
      end
      PH_TAGHDR: begin
        if (rem_q == 16'(TAG_HDR_LEN) &&
            ({1'b0, pos_q} + (POS_W+1)'(TAG_HDR_LEN) > {1'b0, end_w})) begin
          res0    = mk(KIND_TAGHDR_OV);
          n       = 2'd1;
          phase_d = PH_IDLE;
        end else begin
          tag_d = tag_sh;
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            if ({1'b0, tag_sh[15:0]} > left) begin
              res0    = mk(KIND_VALUE_OV);
              n       = 2'd1;
              phase_d = PH_IDLE;
            end else begin
              res0            = mk(KIND_TAG);
              res0.tag_type   = tag_sh[31:16];
              res0.tag_length = tag_sh[15:0];
              n               = 2'd1;
              if (tag_sh[15:0] != '0) begin
                phase_d = PH_VALUE;
                rem_d   = tag_sh[15:0];
              end else if (left == '0) begin
                res1    = mk(KIND_DONE);
                n       = 2'd2;
                phase_d = PH_IDLE;
              end else begin
                rem_d = 16'(TAG_HDR_LEN);
                tag_d = '0;
              end
            end
          end
        end
      end
      PH_VALUE: begin
        res0            = mk(KIND_VALUE);
        res0.value_byte = b;
        n               = 2'd1;
        rem_d           = rem_dec;
        if (rem_dec == '0) begin
          if (pos_p1 >= {1'b0, end_w}) begin
            res1    = mk(KIND_DONE);
            n       = 2'd2;
            phase_d = PH_IDLE;
          end else begin
            phase_d = PH_TAGHDR;
            rem_d   = 16'(TAG_HDR_LEN);
            tag_d   = '0;
          end
        end
      end
      PH_IDLE: begin
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    if (word_i.last_byte) begin
      // early end of packet reports a short capture
      if (phase_d != PH_IDLE && n != 2'd2) begin
        if (n == 2'd0) begin
          res0 = mk(KIND_SHORT);
        end else begin
          res1 = mk(KIND_SHORT);
        end
        n = n + 2'd1;
      end
      phase_d = PH_HEADER;
      pos_d   = '0;
      hdr_d   = '0;
      tag_d   = '0;
      rem_d   = '0;
    end

    if (n == 2'd1) begin
      res0.last_of_run = 1'b1;
    end else if (n == 2'd2) begin
      res1.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= '0;
      hdr_q   <= '0;
      tag_q   <= '0;
      rem_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      hdr_q   <= hdr_d;
      tag_q   <= tag_d;
      rem_q   <= rem_d;
    end
  end

  assign push_o.cnt = accept_i ? n : 2'd0;
  assign push_o.w0  = res0;
  assign push_o.w1  = res1;

endmodule

// ----- rtl/pdtp_res_queue.sv -----
// result queue: takes up to two result words a cycle, hands out one while out_ready_i is high
// depends on pdtp_pkg
module pdtp_res_queue import pdtp_pkg::*; #(
  parameter int unsigned Depth = RES_DEPTH_DFLT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  out_word_t        mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, wptr_p1;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             pop;

  function automatic logic [PtrW-1:0] inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_word_o  = mem_q[rptr_q];
  assign room_o      = (cnt_q <= CntW'(Depth - 2));
  assign wptr_p1     = inc(wptr_q);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = pop ? inc(rptr_q) : rptr_q;
    cnt_d  = cnt_q + CntW'(push_i.cnt) - CntW'(pop);
    if (push_i.cnt == 2'd1) begin
      wptr_d = wptr_p1;
    end else if (push_i.cnt == 2'd2) begin
      wptr_d = inc(wptr_p1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wptr_q] <= push_i.w0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wptr_p1] <= push_i.w1;
    end
  end

endmodule

// ----- rtl/pdtp_checker.sv -----
// port-level checks for the pppoe discovery tag parser, bound to the top
// depends on pdtp_pkg and pppoe_discovery_tag_parser_macros.svh
`include "pppoe_discovery_tag_parser_macros.svh"

module pdtp_checker import pdtp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_word_o
);

  logic end_kind;
  logic hdr_kind;
  logic tag_fields_zero;
  logic out_stall;

  assign end_kind        = out_valid_o && (out_word_o.result_kind >= KIND_DONE);
  assign hdr_kind        = out_valid_o && (out_word_o.result_kind == KIND_HEADER);
  assign tag_fields_zero = (out_word_o.tag_type == '0) && (out_word_o.tag_length == '0) &&
                           (out_word_o.value_byte == '0);
  assign out_stall       = out_valid_o && !out_ready_i;

  `PDTP_ASSERT_NOW(a_kind_range, out_valid_o, out_word_o.result_kind <= KIND_VALUE_OV, "bad kind")

  `PDTP_ASSERT_NOW(a_end_is_last, end_kind, out_word_o.last_of_run, "end not last of run")

  `PDTP_ASSERT_NOW(a_header_clean, hdr_kind, tag_fields_zero, "header carries tag fields")

  `PDTP_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(out_word_o), "stalled word changed")

endmodule

bind pppoe_discovery_tag_parser pdtp_checker u_pdtp_checker (.*);

// ----- test/pppoe_tb_pkg.sv -----
// record checker for the pppoe discovery tag parser testbench: predicts the
// header, tag, value and status records of each accepted byte and checks them
// depends on pdtp_pkg
package pppoe_tb_pkg;
  import pdtp_pkg::*;

  class pppoe_record_checker;
    out_word_t   pending_records[$];
    int unsigned mismatches;

    phase_e      phase;
    int unsigned position;
    logic [47:0] hdr_bytes;
    logic [31:0] tag_bytes;
    logic [15:0] remaining;

    function new();
      mismatches = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase     = PH_HEADER;
      position  = 0;
      hdr_bytes = '0;
      tag_bytes = '0;
      remaining = '0;
    endfunction

    function out_word_t make_record(result_kind_e kind);
      out_word_t r;
      r = '0;
      r.result_kind = kind;
      return r;
    endfunction

    function int unsigned pending();
      return pending_records.size();
    endfunction

    // returns 1 when the byte was not dropped by the idle phase
    function bit note_byte(in_word_t w);
      out_word_t   run[$];
      out_word_t   r;
      int unsigned pos;
      int unsigned stop;
      int unsigned left;
      logic [15:0] plen;
      logic [15:0] tlen;
      bit          live;
      live = (phase != PH_IDLE);
      pos  = position;
      stop = HDR_LEN + hdr_bytes[15:0];
      case (phase)
        PH_HEADER: begin
          hdr_bytes = {hdr_bytes[39:0], w.data_byte};
          if (pos == 0 && w.captured_length < HDR_LEN) begin
            run.push_back(make_record(KIND_SHORT));
            phase = PH_IDLE;
          end else if (pos == HDR_LEN - 1) begin
            plen = hdr_bytes[15:0];
            if (plen + HDR_LEN > w.captured_length) begin
              run.push_back(make_record(KIND_SHORT));
              phase = PH_IDLE;
            end else begin
              r = make_record(KIND_HEADER);
              r.version        = hdr_bytes[47:44];
              r.frame_type     = hdr_bytes[43:40];
              r.code           = hdr_bytes[39:32];
              r.session_id     = hdr_bytes[31:16];
              r.payload_length = plen;
              run.push_back(r);
              if (plen == 0) begin
                run.push_back(make_record(KIND_DONE));
                phase = PH_IDLE;
              end else begin
                phase     = PH_TAGHDR;
                remaining = TAG_HDR_LEN;
                tag_bytes = '0;
              end
            end
          end
        end
        PH_TAGHDR: begin
          if (remaining == TAG_HDR_LEN && (pos >= stop || stop - pos < TAG_HDR_LEN)) begin
            run.push_back(make_record(KIND_TAGHDR_OV));
            phase = PH_IDLE;
          end else begin
            tag_bytes = {tag_bytes[23:0], w.data_byte};
            if (remaining != 0) remaining--;
            if (remaining == 0) begin
              tlen = tag_bytes[15:0];
              left = (pos + 1 < stop) ? stop - pos - 1 : 0;
              if (tlen > left) begin
                run.push_back(make_record(KIND_VALUE_OV));
                phase = PH_IDLE;
              end else begin
                r = make_record(KIND_TAG);
                r.tag_type   = tag_bytes[31:16];
                r.tag_length = tlen;
                run.push_back(r);
                if (tlen != 0) begin
                  phase     = PH_VALUE;
                  remaining = tlen;
                end else if (left == 0) begin
                  run.push_back(make_record(KIND_DONE));
                  phase = PH_IDLE;
                end else begin
                  remaining = TAG_HDR_LEN;
                  tag_bytes = '0;
                end
              end
            end
          end
        end
        PH_VALUE: begin
          r = make_record(KIND_VALUE);
          r.value_byte = w.data_byte;
          run.push_back(r);
          if (remaining != 0) remaining--;
          if (remaining == 0) begin
            if (pos + 1 >= stop) begin
              run.push_back(make_record(KIND_DONE));
              phase = PH_IDLE;
            end else begin
              phase     = PH_TAGHDR;
              remaining = TAG_HDR_LEN;
              tag_bytes = '0;
            end
          end
        end
        default: ;
      endcase
      position = (pos < (1 << POS_W) - 1) ? pos + 1 : (1 << POS_W) - 1;
      if (w.last_byte) begin
        if (phase != PH_IDLE && run.size() < 2) run.push_back(make_record(KIND_SHORT));
        clear_state();
      end
      if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
      foreach (run[i]) pending_records.push_back(run[i]);
      return live;
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got,
                                longint unsigned stamp);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0d ns: %s expected %h got %h", stamp, field, want, got);
      end
    endfunction

    function void check_record(out_word_t got, longint unsigned stamp);
      out_word_t want;
      if (pending_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0d ns: word expected none got %h", stamp, got);
        return;
      end
      want = pending_records.pop_front();
      compare_field("result_kind", 16'(want.result_kind), 16'(got.result_kind), stamp);
      compare_field("version", 16'(want.version), 16'(got.version), stamp);
      compare_field("frame_type", 16'(want.frame_type), 16'(got.frame_type), stamp);
      compare_field("code", 16'(want.code), 16'(got.code), stamp);
      compare_field("session_id", want.session_id, got.session_id, stamp);
      compare_field("payload_length", want.payload_length, got.payload_length, stamp);
      compare_field("tag_type", want.tag_type, got.tag_type, stamp);
      compare_field("tag_length", want.tag_length, got.tag_length, stamp);
      compare_field("value_byte", 16'(want.value_byte), 16'(got.value_byte), stamp);
      compare_field("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run), stamp);
    endfunction
  endclass

endpackage

// ----- test/tb_pppoe_discovery_tag_parser.sv -----
// top testbench for pppoe_discovery_tag_parser: drives directed and random
// discovery packets byte by byte with random gaps and output stalls
// depends on pdtp_pkg, pppoe_tb_pkg and the parser rtl
module tb_pppoe_discovery_tag_parser;
  import pdtp_pkg::*;
  import pppoe_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_q_t[$];

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned LiveBytes  = 1400;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_word_o;

  pppoe_record_checker sb;
  int unsigned live_count;
  int unsigned idle_cycles;
  int unsigned stall_left;
  int unsigned pause_len;
  bit          calm;

  pppoe_discovery_tag_parser u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned pick_tag_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return 0;
    if (r < 95) return $urandom_range(1, 12);
    return $urandom_range(40, 90);
  endfunction

  function automatic void build_packet(output byte_q_t pkt, output logic [15:0] cap);
    byte_q_t     body;
    int unsigned flavor;
    int unsigned tlen;
    int unsigned extra;
    int unsigned plen;
    int unsigned keep;
    int unsigned trail;
    logic [15:0] ttype;
    flavor = $urandom_range(0, 99);
    pkt.delete();
    trail = 0;
    repeat ($urandom_range(0, 4)) begin
      ttype = $urandom_range(0, 1) ? 16'h0100 + 16'($urandom_range(0, 4))
                                   : 16'($urandom_range(0, 16'hFFFF));
      tlen = pick_tag_len();
      body.push_back(ttype[15:8]);
      body.push_back(ttype[7:0]);
      body.push_back(8'(tlen >> 8));
      body.push_back(8'(tlen));
      repeat (tlen) body.push_back(8'($urandom_range(0, 255)));
    end
    // broken tail: stub shorter than a tag header, or a tag longer than the payload
    if (flavor >= 65 && flavor < 72) begin
      repeat ($urandom_range(1, 3)) body.push_back(8'($urandom_range(0, 255)));
    end else if (flavor >= 72 && flavor < 79) begin
      tlen  = $urandom_range(1, 65535);
      extra = $urandom_range(0, 3);
      if (extra >= tlen) extra = tlen - 1;
      body.push_back(8'($urandom_range(0, 255)));
      body.push_back(8'($urandom_range(0, 255)));
      body.push_back(8'(tlen >> 8));
      body.push_back(8'(tlen));
      repeat (extra) body.push_back(8'($urandom_range(0, 255)));
    end
    plen = body.size();
    pkt.push_back(($urandom_range(0, 3) != 0) ? 8'h11 : 8'($urandom_range(0, 255)));
    case ($urandom_range(0, 5))
      0: pkt.push_back(8'h09);
      1: pkt.push_back(8'h07);
      2: pkt.push_back(8'h19);
      3: pkt.push_back(8'h65);
      4: pkt.push_back(8'hA7);
      default: pkt.push_back(8'($urandom_range(0, 255)));
    endcase
    pkt.push_back(8'($urandom_range(0, 255)));
    pkt.push_back(8'($urandom_range(0, 255)));
    pkt.push_back(8'(plen >> 8));
    pkt.push_back(8'(plen));
    foreach (body[i]) pkt.push_back(body[i]);
    if (flavor >= 79 && flavor < 85) begin
      cap = 16'($urandom_range(0, 5 + plen));
    end else if ($urandom_range(0, 3) == 0) begin
      cap   = 16'($urandom_range(6 + plen, 65535));
      trail = $urandom_range(0, 2);
    end else begin
      trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      cap   = 16'(6 + plen + trail);
    end
    repeat (trail) pkt.push_back(8'($urandom_range(0, 255)));
    if (flavor >= 85 && flavor < 93 && pkt.size() > 1) begin
      keep = $urandom_range(1, pkt.size() - 1);
      while (pkt.size() > keep) void'(pkt.pop_back());
    end
    if (flavor >= 93) begin
      pkt.delete();
      repeat ($urandom_range(1, 20)) pkt.push_back(8'($urandom_range(0, 255)));
      cap = 16'($urandom_range(0, 65535));
    end
  endfunction

  task automatic send_byte(input in_word_t w);
    int unsigned gap;
    gap = pick_pause();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    if (sb.note_byte(w)) live_count++;
  endtask

  task automatic send_packet(input byte_q_t pkt, input logic [15:0] cap);
    in_word_t w;
    foreach (pkt[i]) begin
      w.data_byte       = pkt[i];
      w.captured_length = cap;
      w.last_byte       = (i == pkt.size() - 1);
      send_byte(w);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  = 0;
    end else begin
      if (out_valid_o && out_ready_i) sb.check_record(out_word_o, $time);
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        pause_len = pick_pause();
        out_ready_i <= (pause_len == 0);
        stall_left = (pause_len == 0) ? 0 : pause_len - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: timeout, %0d words outstanding", $time, sb.pending());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    byte_q_t     pkt;
    logic [15:0] cap;
    sb          = new();
    live_count  = 0;
    idle_cycles = 0;
    stall_left  = 0;
    calm        = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_word_i   <= '0;
    out_ready_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // tiny capture
    send_packet('{8'h00}, 16'h0000);
    // empty payload with all-ones header fields
    send_packet('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00}, 16'd6);
    // payload longer than the capture
    send_packet('{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF}, 16'hFFFF);
    // one tag whose single value byte ends the payload
    send_packet('{8'h11, 8'h07, 8'h12, 8'h34, 8'h00, 8'h05,
                  8'hFF, 8'hFF, 8'h00, 8'h01, 8'hFF}, 16'd11);

    while (live_count < LiveBytes) begin
      calm = ($urandom_range(0, 4) == 0);
      build_packet(pkt, cap);
      send_packet(pkt, cap);
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/pdtp_pkg.sv
rtl/pdtp_parse.sv
rtl/pdtp_res_queue.sv
rtl/pppoe_discovery_tag_parser.sv
rtl/pdtp_checker.sv
test/pppoe_tb_pkg.sv
test/tb_pppoe_discovery_tag_parser.sv
